// File: hdl/acs_pkg.sv
// acs_pkg: shared types and constants for the anchored coordinate set
// no dependencies; used by the top level and the testbench
package acs_pkg;

	localparam int CFG_W = 5;
	localparam logic [CFG_W-1:0] ENTRY_LIMIT_RST = 5'd10;

	typedef enum logic [1:0] {
		FN_ADD    = 2'd0,
		FN_ERASE  = 2'd1,
		FN_ANCHOR = 2'd2,
		FN_EXPORT = 2'd3
	} func_t;

	typedef enum logic [2:0] {
		ST_DONE      = 3'd0,
		ST_DUPLICATE = 3'd1,
		ST_FULL      = 3'd2,
		ST_NOT_FOUND = 3'd3,
		ST_EXPORT    = 3'd4
	} status_t;

	typedef enum logic [8:0] {
		S_IDLE     = 9'b000000001,
		S_SCAN_RD  = 9'b000000010,
		S_SCAN_CMP = 9'b000000100,
		S_SHIFT_RD = 9'b000001000,
		S_SHIFT_WR = 9'b000010000,
		S_EXP_RD   = 9'b000100000,
		S_EXP_SUB  = 9'b001000000,
		S_DEF      = 9'b010000000,
		S_OUT      = 9'b100000000
	} state_t;

	// offsets sent when no anchor has been set
	localparam int DEF_COUNT = 4;
	localparam logic [1:0] DEF_LAST = 2'd3;
	localparam logic signed [1:0] DEF_X [DEF_COUNT] = '{2'sd0, 2'sd0, 2'sd1, -2'sd1};
	localparam logic signed [1:0] DEF_Y [DEF_COUNT] = '{2'sd0, -2'sd1, 2'sd0, 2'sd0};

endpackage

// File: hdl/acs_in_if.sv
// acs_in_if: command channel of the anchored coordinate set
// depends on nothing; one beat carries a command and a coordinate
interface acs_in_if #(
	parameter int COORD_BITS = 10
);
	logic                         valid;
	logic                         ready;
	logic [1:0]                   func;
	logic signed [COORD_BITS-1:0] pos_x;
	logic signed [COORD_BITS-1:0] pos_y;

	modport source (output valid, func, pos_x, pos_y, input ready);
	modport sink (input valid, func, pos_x, pos_y, output ready);
endinterface

// File: hdl/acs_out_if.sv
// acs_out_if: result channel of the anchored coordinate set
// depends on nothing; one beat carries a status and an offset pair
interface acs_out_if #(
	parameter int COORD_BITS = 10
);
	logic                       valid;
	logic                       ready;
	logic [2:0]                 status;
	logic signed [COORD_BITS:0] offset_x;
	logic signed [COORD_BITS:0] offset_y;
	logic                       last;

	modport source (output valid, status, offset_x, offset_y, last, input ready);
	modport sink (input valid, status, offset_x, offset_y, last, output ready);
endinterface

// File: hdl/acs_ram.sv
// acs_ram: generic single-write, single-read ram with registered read data
// no dependencies
module acs_ram #(
	parameter int WIDTH = 20,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end
endmodule

// File: hdl/anchored_coordinate_set.sv
// Anchored coordinate set: keeps an ordered list of up to MAX_ENTRIES grid
// coordinates without duplicates, bounded by the entry_limit register, plus one
// anchor. Commands are add, erase, set anchor and export; each edit returns one
// status beat, an export returns (0,0) then each entry's offset from the anchor
// (or four default offsets when no anchor is set), last marking the final beat.
// Commands are handled one at a time by a sequencer around a ram with one write
// port and one read port, and one compare/subtract unit. An add or erase scans
// the list one entry at a time, reading then comparing; an add appends at the end
// when nothing matches and the limit allows, and an erase that hits closes the gap
// by moving each later entry down one place. An anchored export reads each entry
// and subtracts the anchor from it. A pending beat is held while out ready is low.
// in ready is high only while no command is open.
// depends on acs_pkg, acs_in_if, acs_out_if and acs_ram
module anchored_coordinate_set
	import acs_pkg::*;
#(
	parameter int MAX_ENTRIES = 16,
	parameter int COORD_BITS  = 10
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cfg_we,
	input  logic [CFG_W-1:0] cfg_wdata,
	acs_in_if.sink           in_ch,
	acs_out_if.source        out_ch
);
	localparam int AW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
	localparam int CW = $clog2(MAX_ENTRIES + 1);
	localparam int LW = (CW > CFG_W) ? CW : CFG_W;
	localparam int OW = COORD_BITS + 1;
	localparam int EW = 2 * COORD_BITS;

	state_t                       state_q, nxt_q;
	logic [CFG_W-1:0]             limit_q;
	logic [CW-1:0]                count_q, idx_q;
	logic [EW-1:0]                anchor_q;
	logic                         anchor_vld_q;
	logic [1:0]                   func_q;
	logic [EW-1:0]                item_q;
	logic [2:0]                   status_q;
	logic signed [OW-1:0]         dx_q, dy_q;
	logic                         last_q;

	logic                         ram_we;
	logic [AW-1:0]                ram_waddr, ram_raddr;
	logic [EW-1:0]                ram_wdata, ram_rdata;
	logic [CW-1:0]                idx_inc;
	logic [LW-1:0]                limit_eff;
	logic                         is_full, match;
	logic signed [COORD_BITS-1:0] rd_x, rd_y, anc_x, anc_y;
	logic signed [OW-1:0]         diff_x, diff_y;

	acs_ram #(
		.WIDTH(EW),
		.DEPTH(MAX_ENTRIES)
	) u_store (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	// shared compare and subtract unit
	assign idx_inc   = idx_q + 1'b1;
	assign limit_eff = (LW'(limit_q) > LW'(MAX_ENTRIES)) ? LW'(MAX_ENTRIES) : LW'(limit_q);
	assign is_full   = LW'(count_q) >= limit_eff;
	assign match     = ram_rdata == item_q;
	assign rd_x      = ram_rdata[EW-1:COORD_BITS];
	assign rd_y      = ram_rdata[COORD_BITS-1:0];
	assign anc_x     = anchor_q[EW-1:COORD_BITS];
	assign anc_y     = anchor_q[COORD_BITS-1:0];
	assign diff_x    = OW'(rd_x) - OW'(anc_x);
	assign diff_y    = OW'(rd_y) - OW'(anc_y);

	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = count_q[AW-1:0];
		ram_wdata = item_q;
		ram_raddr = idx_q[AW-1:0];
		case (state_q)
			S_SCAN_RD: begin
				// append when the scan ran off the end without a hit
				ram_we = (idx_q == count_q) && (func_q == FN_ADD) && !is_full;
			end
			S_SHIFT_RD: begin
				ram_raddr = idx_inc[AW-1:0];
			end
			S_SHIFT_WR: begin
				ram_we    = 1'b1;
				ram_waddr = idx_q[AW-1:0];
				ram_wdata = ram_rdata;
			end
			default: begin
			end
		endcase
	end

	assign in_ch.ready     = state_q == S_IDLE;
	assign out_ch.valid    = state_q == S_OUT;
	assign out_ch.status   = status_q;
	assign out_ch.offset_x = dx_q;
	assign out_ch.offset_y = dy_q;
	assign out_ch.last     = last_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			nxt_q        <= S_IDLE;
			limit_q      <= ENTRY_LIMIT_RST;
			count_q      <= '0;
			idx_q        <= '0;
			anchor_q     <= '0;
			anchor_vld_q <= 1'b0;
			func_q       <= '0;
			item_q       <= '0;
			status_q     <= '0;
			dx_q         <= '0;
			dy_q         <= '0;
			last_q       <= 1'b0;
		end else begin
			if (cfg_we) begin
				limit_q <= cfg_wdata;
			end
			case (state_q)
				S_IDLE: begin
					if (in_ch.valid) begin
						func_q   <= in_ch.func;
						item_q   <= {in_ch.pos_x, in_ch.pos_y};
						idx_q    <= '0;
						status_q <= ST_DONE;
						dx_q     <= '0;
						dy_q     <= '0;
						last_q   <= 1'b1;
						nxt_q    <= S_IDLE;
						case (func_t'(in_ch.func))
							FN_ADD, FN_ERASE: begin
								state_q <= S_SCAN_RD;
							end
							FN_ANCHOR: begin
								anchor_q     <= {in_ch.pos_x, in_ch.pos_y};
								anchor_vld_q <= 1'b1;
								state_q      <= S_OUT;
							end
							FN_EXPORT: begin
								if (anchor_vld_q) begin
									status_q <= ST_EXPORT;
									last_q   <= count_q == '0;
									nxt_q    <= S_EXP_RD;
									state_q  <= S_OUT;
								end else begin
									state_q <= S_DEF;
								end
							end
							default: begin
								state_q <= S_IDLE;
							end
						endcase
					end
				end
				S_SCAN_RD: begin
					if (idx_q == count_q) begin
						if (func_q == FN_ADD) begin
							if (is_full) begin
								status_q <= ST_FULL;
							end else begin
								count_q <= count_q + 1'b1;
							end
						end else begin
							status_q <= ST_NOT_FOUND;
						end
						state_q <= S_OUT;
					end else begin
						state_q <= S_SCAN_CMP;
					end
				end
				S_SCAN_CMP: begin
					if (match) begin
						if (func_q == FN_ADD) begin
							status_q <= ST_DUPLICATE;
							state_q  <= S_OUT;
						end else begin
							state_q <= S_SHIFT_RD;
						end
					end else begin
						idx_q   <= idx_inc;
						state_q <= S_SCAN_RD;
					end
				end
				S_SHIFT_RD: begin
					if (idx_inc == count_q) begin
						count_q <= count_q - 1'b1;
						state_q <= S_OUT;
					end else begin
						state_q <= S_SHIFT_WR;
					end
				end
				S_SHIFT_WR: begin
					idx_q   <= idx_inc;
					state_q <= S_SHIFT_RD;
				end
				S_EXP_RD: begin
					state_q <= S_EXP_SUB;
				end
				S_EXP_SUB: begin
					dx_q    <= diff_x;
					dy_q    <= diff_y;
					last_q  <= idx_inc == count_q;
					idx_q   <= idx_inc;
					nxt_q   <= S_EXP_RD;
					state_q <= S_OUT;
				end
				S_DEF: begin
					status_q <= ST_EXPORT;
					dx_q     <= {{(OW-2){DEF_X[idx_q[1:0]][1]}}, DEF_X[idx_q[1:0]]};
					dy_q     <= {{(OW-2){DEF_Y[idx_q[1:0]][1]}}, DEF_Y[idx_q[1:0]]};
					last_q   <= idx_q[1:0] == DEF_LAST;
					idx_q    <= idx_inc;
					nxt_q    <= S_DEF;
					state_q  <= S_OUT;
				end
				S_OUT: begin
					// hold the beat until taken, then resume or finish
					if (out_ch.ready) begin
						state_q <= last_q ? S_IDLE : nxt_q;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	a_no_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		!(in_ch.ready && out_ch.valid))
		else $error("command taken while a result beat is pending");

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(MAX_ENTRIES))
		else $error("entry count above built depth");

	a_edit_single: assert property (@(posedge clk) disable iff (!arst_n)
		out_ch.valid && (out_ch.status != ST_EXPORT)
		|-> out_ch.last && (out_ch.offset_x == '0) && (out_ch.offset_y == '0))
		else $error("edit result is not a single zero-offset beat");

	a_anchor_set: assert property (@(posedge clk) disable iff (!arst_n)
		in_ch.valid && in_ch.ready && (in_ch.func == FN_ANCHOR) |=> anchor_vld_q)
		else $error("anchor not marked valid after set-anchor beat");

endmodule

// File: test/anchored_coordinate_set_tb.sv
// anchored_coordinate_set_tb: self-checking bench for the anchored coordinate set
// depends on acs_pkg, acs_in_if, acs_out_if and the anchored_coordinate_set top level
// commands go in through a queued driver; result beats are checked against an in-bench predictor
`timescale 1ns / 100ps

module anchored_coordinate_set_tb;
	import acs_pkg::*;

	localparam int MAX_ENTRIES = 16;
	localparam int COORD_BITS = 10;
	localparam int STALL_LIMIT = 2000;

	typedef logic signed [COORD_BITS-1:0] coord_t;
	typedef logic signed [COORD_BITS:0] offset_t;

	typedef struct {
		func_t  func;
		coord_t x;
		coord_t y;
	} coord_cmd_t;

	typedef struct {
		status_t status;
		offset_t dx;
		offset_t dy;
		logic    last;
	} result_beat_t;

	logic clk = 1'b0;
	logic arst_n;
	logic cfg_we;
	logic [CFG_W-1:0] cfg_wdata;

	acs_in_if #(.COORD_BITS(COORD_BITS)) in_ch();
	acs_out_if #(.COORD_BITS(COORD_BITS)) out_ch();

	anchored_coordinate_set #(
		.MAX_ENTRIES(MAX_ENTRIES),
		.COORD_BITS(COORD_BITS)
	) u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_wdata(cfg_wdata),
		.in_ch(in_ch),
		.out_ch(out_ch)
	);

	always #6 clk = ~clk;

	// predictor state
	coord_t set_x [MAX_ENTRIES];
	coord_t set_y [MAX_ENTRIES];
	int set_count = 0;
	coord_t anchor_x = '0;
	coord_t anchor_y = '0;
	logic anchor_ok = 1'b0;
	logic [CFG_W-1:0] limit_reg = ENTRY_LIMIT_RST;

	coord_cmd_t pending_cmds [$];
	result_beat_t expected_beats [$];
	int errors = 0;
	int send_gap;
	int recv_stall;
	logic tx_idle_en = 1'b0;
	logic rx_idle_en = 1'b0;
	int quiet_cycles = 0;

	// stimulus coordinate pool, redrawn per phase so adds and erases collide
	coord_t pool_x [24];
	coord_t pool_y [24];
	int pool_n = 8;

	function automatic int locate(coord_t x, coord_t y);
		for (int i = 0; i < set_count; i++) begin
			if (set_x[i] == x && set_y[i] == y)
				return i;
		end
		return -1;
	endfunction

	function automatic void push_beat(status_t st, offset_t dx, offset_t dy, logic last);
		result_beat_t b;
		b.status = st;
		b.dx = dx;
		b.dy = dy;
		b.last = last;
		expected_beats.insert(expected_beats.size(), b);
	endfunction

	function automatic void predict_cmd(coord_cmd_t c);
		int hit;
		int cap;
		offset_t dx;
		offset_t dy;
		cap = (limit_reg > MAX_ENTRIES) ? MAX_ENTRIES : int'(limit_reg);
		case (c.func)
			FN_ADD: begin
				hit = locate(c.x, c.y);
				if (hit >= 0) begin
					push_beat(ST_DUPLICATE, '0, '0, 1'b1);
				end else if (set_count >= cap) begin
					push_beat(ST_FULL, '0, '0, 1'b1);
				end else begin
					set_x[set_count] = c.x;
					set_y[set_count] = c.y;
					set_count++;
					push_beat(ST_DONE, '0, '0, 1'b1);
				end
			end
			FN_ERASE: begin
				hit = locate(c.x, c.y);
				if (hit < 0) begin
					push_beat(ST_NOT_FOUND, '0, '0, 1'b1);
				end else begin
					for (int i = hit; i + 1 < set_count; i++) begin
						set_x[i] = set_x[i+1];
						set_y[i] = set_y[i+1];
					end
					set_count--;
					push_beat(ST_DONE, '0, '0, 1'b1);
				end
			end
			FN_ANCHOR: begin
				anchor_x = c.x;
				anchor_y = c.y;
				anchor_ok = 1'b1;
				push_beat(ST_DONE, '0, '0, 1'b1);
			end
			default: begin
				if (!anchor_ok) begin
					push_beat(ST_EXPORT, 11'sd0, 11'sd0, 1'b0);
					push_beat(ST_EXPORT, 11'sd0, -11'sd1, 1'b0);
					push_beat(ST_EXPORT, 11'sd1, 11'sd0, 1'b0);
					push_beat(ST_EXPORT, -11'sd1, 11'sd0, 1'b1);
				end else begin
					push_beat(ST_EXPORT, '0, '0, set_count == 0);
					for (int i = 0; i < set_count; i++) begin
						// widen by one bit before the subtract so extremes do not wrap
						dx = offset_t'({set_x[i][COORD_BITS-1], set_x[i]})
							- offset_t'({anchor_x[COORD_BITS-1], anchor_x});
						dy = offset_t'({set_y[i][COORD_BITS-1], set_y[i]})
							- offset_t'({anchor_y[COORD_BITS-1], anchor_y});
						push_beat(ST_EXPORT, dx, dy, i + 1 == set_count);
					end
				end
			end
		endcase
	endfunction

	// command driver
	always @(posedge clk or negedge arst_n) begin : drive_cmds
		coord_cmd_t nxt;
		coord_cmd_t seen;
		if (!arst_n) begin
			in_ch.valid <= 1'b0;
			in_ch.func <= FN_ADD;
			in_ch.pos_x <= '0;
			in_ch.pos_y <= '0;
			send_gap <= 0;
		end else begin
			if (in_ch.valid && in_ch.ready) begin
				seen.func = func_t'(in_ch.func);
				seen.x = in_ch.pos_x;
				seen.y = in_ch.pos_y;
				predict_cmd(seen);
			end
			if (!in_ch.valid || in_ch.ready) begin
				if (send_gap > 0 || pending_cmds.size() == 0) begin
					in_ch.valid <= 1'b0;
					if (send_gap > 0)
						send_gap <= send_gap - 1;
				end else begin
					nxt = pending_cmds.pop_front();
					in_ch.valid <= 1'b1;
					in_ch.func <= nxt.func;
					in_ch.pos_x <= nxt.x;
					in_ch.pos_y <= nxt.y;
					send_gap <= tx_idle_en ? $urandom_range(0, 10) : 0;
				end
			end
		end
	end

	// result monitor and checker
	always @(posedge clk or negedge arst_n) begin : check_results
		result_beat_t want;
		int pause;
		if (!arst_n) begin
			out_ch.ready <= 1'b0;
			recv_stall <= 0;
		end else begin
			if (out_ch.valid && out_ch.ready) begin
				if (expected_beats.size() == 0) begin
					$error("unexpected result beat: status %0d offset (%0d,%0d) last %0b",
						out_ch.status, out_ch.offset_x, out_ch.offset_y, out_ch.last);
					errors++;
				end else begin
					want = expected_beats.pop_front();
					if (out_ch.status !== want.status) begin
						$error("status: expected %0d, got %0d", want.status, out_ch.status);
						errors++;
					end
					if (out_ch.offset_x !== want.dx) begin
						$error("offset_x: expected %0d, got %0d", want.dx, out_ch.offset_x);
						errors++;
					end
					if (out_ch.offset_y !== want.dy) begin
						$error("offset_y: expected %0d, got %0d", want.dy, out_ch.offset_y);
						errors++;
					end
					if (out_ch.last !== want.last) begin
						$error("last: expected %0b, got %0b", want.last, out_ch.last);
						errors++;
					end
				end
				pause = rx_idle_en ? $urandom_range(0, 10) : 0;
				recv_stall <= pause;
				out_ch.ready <= (pause == 0);
			end else if (recv_stall > 0) begin
				recv_stall <= recv_stall - 1;
				out_ch.ready <= (recv_stall == 1);
			end else begin
				out_ch.ready <= 1'b1;
			end
		end
	end

	// watchdog: ends the run if no beat moves on either side for too long
	always @(posedge clk) begin
		if (arst_n === 1'b1) begin
			if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
				quiet_cycles <= 0;
			else
				quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles >= STALL_LIMIT) begin
				$display("[FAIL] regression broken");
				$finish;
			end
		end
	end

	task automatic queue_cmd(func_t f, coord_t x, coord_t y);
		coord_cmd_t c;
		c.func = f;
		c.x = x;
		c.y = y;
		pending_cmds.insert(pending_cmds.size(), c);
	endtask

	task automatic wait_drained();
		@(negedge clk);
		while (pending_cmds.size() != 0 || in_ch.valid || expected_beats.size() != 0)
			@(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	task automatic write_limit(logic [CFG_W-1:0] v);
		wait_drained();
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_wdata <= v;
		@(posedge clk);
		cfg_we <= 1'b0;
		limit_reg = v;
	endtask

	function automatic coord_t edge_value();
		case ($urandom_range(0, 3))
			0: return 10'sd511;
			1: return -10'sd512;
			2: return 10'sd0;
			default: return -10'sd1;
		endcase
	endfunction

	task automatic refill_pool();
		pool_n = $urandom_range(4, 24);
		for (int i = 0; i < pool_n; i++) begin
			pool_x[i] = ($urandom_range(0, 3) == 0) ? edge_value() : coord_t'($urandom);
			pool_y[i] = ($urandom_range(0, 3) == 0) ? edge_value() : coord_t'($urandom);
		end
	endtask

	task automatic queue_random(int n);
		int r;
		int k;
		func_t f;
		coord_t x;
		coord_t y;
		for (int i = 0; i < n; i++) begin
			r = $urandom_range(0, 99);
			if (r < 42)
				f = FN_ADD;
			else if (r < 70)
				f = FN_ERASE;
			else if (r < 80)
				f = FN_ANCHOR;
			else
				f = FN_EXPORT;
			if ($urandom_range(0, 99) < 15) begin
				x = coord_t'($urandom);
				y = coord_t'($urandom);
			end else begin
				k = $urandom_range(0, pool_n - 1);
				x = pool_x[k];
				y = pool_y[k];
			end
			queue_cmd(f, x, y);
		end
	endtask

	initial begin : run
		logic [CFG_W-1:0] phase_limits [8];
		coord_t fill_y [MAX_ENTRIES+1];
		phase_limits = '{5'd16, 5'd3, 5'd31, 5'd0, 5'd8, 5'd12, 5'd20, 5'd1};
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_wdata = '0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;

		// reset limit: defaults, duplicate, not found, extreme offsets, empty export
		queue_cmd(FN_EXPORT, 10'sd0, 10'sd0);
		queue_cmd(FN_ADD, 10'sd511, -10'sd512);
		queue_cmd(FN_ADD, 10'sd511, -10'sd512);
		queue_cmd(FN_ERASE, 10'sd0, 10'sd0);
		queue_cmd(FN_ADD, -10'sd512, 10'sd511);
		queue_cmd(FN_ANCHOR, -10'sd512, 10'sd511);
		queue_cmd(FN_EXPORT, 10'sd0, 10'sd0);
		queue_cmd(FN_ANCHOR, 10'sd511, -10'sd512);
		queue_cmd(FN_EXPORT, 10'sd0, 10'sd0);
		queue_cmd(FN_ERASE, 10'sd511, -10'sd512);
		queue_cmd(FN_EXPORT, 10'sd0, 10'sd0);
		queue_cmd(FN_ERASE, -10'sd512, 10'sd511);
		queue_cmd(FN_EXPORT, 10'sd0, 10'sd0);

		// zero limit rejects every new coordinate
		write_limit(5'd0);
		queue_cmd(FN_ADD, 10'sd1, 10'sd1);

		// duplicate wins over full
		write_limit(5'd2);
		queue_cmd(FN_ADD, 10'sd3, 10'sd4);
		queue_cmd(FN_ADD, 10'sd5, 10'sd6);
		queue_cmd(FN_ADD, 10'sd7, 10'sd8);
		queue_cmd(FN_ADD, 10'sd3, 10'sd4);

		// limit lowered under the count keeps entries but refuses adds
		write_limit(5'd1);
		queue_cmd(FN_ADD, 10'sd9, 10'sd9);
		queue_cmd(FN_ERASE, 10'sd3, 10'sd4);
		queue_cmd(FN_ADD, 10'sd9, 10'sd9);
		queue_cmd(FN_ERASE, 10'sd5, 10'sd6);
		queue_cmd(FN_ADD, 10'sd9, 10'sd9);
		queue_cmd(FN_ERASE, 10'sd9, 10'sd9);

		// limit above depth: fill to capacity, overflow once, longest export, then drain
		write_limit(5'd31);
		tx_idle_en = 1'b1;
		rx_idle_en = 1'b1;
		queue_cmd(FN_ANCHOR, coord_t'($urandom), coord_t'($urandom));
		for (int i = 0; i <= MAX_ENTRIES; i++) begin
			fill_y[i] = coord_t'($urandom);
			queue_cmd(FN_ADD, coord_t'(i * 60 - 500), fill_y[i]);
		end
		queue_cmd(FN_EXPORT, 10'sd0, 10'sd0);
		for (int i = 0; i < MAX_ENTRIES; i++)
			queue_cmd(FN_ERASE, coord_t'(i * 60 - 500), fill_y[i]);

		for (int p = 0; p < 8; p++) begin
			write_limit(phase_limits[p]);
			tx_idle_en = (p == 0) ? 1'b0 : 1'($urandom);
			rx_idle_en = (p == 0) ? 1'b0 : 1'($urandom);
			refill_pool();
			queue_random(34);
		end

		wait_drained();
		repeat (20) @(negedge clk);
		if (expected_beats.size() != 0) begin
			$error("%0d expected result beats never arrived", expected_beats.size());
			errors++;
		end
		if (errors == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule
